// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the duplicate remover RTL.
// Depends on nothing; the assertion bodies are dropped when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every clock edge outside of reset.
`define SDR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every clock edge, during reset as well.
`define SDR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SDR_ASSERT(label, prop, msg)
`define SDR_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/core/sdr_pkg.sv =====
// Package for the stream duplicate remover: widths, depths, the item type
// and the search engine state type. Depends on nothing.
`timescale 1ns / 1ps

package sdr_pkg;

    // Data width of one list element.
    localparam int SDR_VALUE_W = 32;

    // Default number of distinct values the store can hold.
    localparam int SDR_DEPTH = 64;

    // Entries in the queue between the front and the search engine.
    localparam int SDR_QDEPTH = 2;

    // One accepted list element as it travels through the queue.
    typedef struct packed {
        logic signed [SDR_VALUE_W-1:0] value;
        logic                          last;
    } t_item;

    // Search engine states.
    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

endpackage

// ===== rtl/core/sdr_front.sv =====
// Front end of the duplicate remover: accepts transactions into a short queue.
// Depends on sdr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sdr_front
    import sdr_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SDR_VALUE_W-1:0] i_value,
    input  logic                          i_last,
    input  logic                          i_pop,
    output logic                          o_item_valid,
    output t_item                         o_item
);

    localparam int QAW = (SDR_QDEPTH > 1) ? $clog2(SDR_QDEPTH) : 1;
    localparam int QCW = $clog2(SDR_QDEPTH + 1);

    t_item          r_q [SDR_QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] n_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW-1:0] n_rp;
    logic [QCW-1:0] r_cnt;
    logic [QCW-1:0] n_cnt;
    logic           full;
    logic           push;

    // The queue refuses new transactions only when it is full.
    assign full         = (r_cnt == QCW'(SDR_QDEPTH));
    assign busy         = full;
    assign push         = start && !full;
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rp];

    // Pointer and fill count updates.
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QAW'(SDR_QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == QAW'(SDR_QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{value: i_value, last: i_last};
        end
    end

    `SDR_ASSERT(a_cnt_bound, r_cnt <= QCW'(SDR_QDEPTH), "queue count above its depth")
    `SDR_ASSERT(a_pop_nonempty, i_pop |-> (r_cnt != '0), "pop from an empty queue")
    `SDR_ASSERT(a_cnt_up, (push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1),
        "queue count did not follow a push")

endmodule

// ===== rtl/core/sdr_back.sv =====
// Search engine of the duplicate remover: scans the store of distinct values
// and issues one result per transaction. Depends on sdr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sdr_back
    import sdr_pkg::*;
#(
    parameter int DEPTH = SDR_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  t_item                         i_item,
    output logic                          o_pop,
    output logic                          o_strobe,
    output logic signed [SDR_VALUE_W-1:0] o_value_out,
    output logic                          o_keep,
    output logic                          o_last_out,
    output logic                          o_overflow
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state                  r_state;
    t_state                  n_state;
    t_item                   r_item;
    logic [CW-1:0]           r_idx;
    logic [CW-1:0]           n_idx;
    logic                    r_pend;
    logic                    n_pend;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic [SDR_VALUE_W-1:0]  r_rdata;
    logic                    r_strobe;
    logic                    n_strobe;
    logic signed [SDR_VALUE_W-1:0] r_value_out;
    logic                    r_keep;
    logic                    r_last_out;
    logic                    r_overflow;
    logic                    match;
    logic                    issue;
    logic                    full;
    logic                    finish;
    logic                    rd_en;
    logic                    wr_en;
    logic [SDR_VALUE_W-1:0]  mem [DEPTH];

    // A match needs a returned read; entries at or above the fill count are never read.
    assign match = r_pend && (r_rdata == r_item.value);
    assign issue = (r_idx < r_count);
    assign full  = (r_count == CW'(DEPTH));

    // Next state: while a search runs, one store read issued per cycle, the previous one compared.
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_count  = r_count;
        n_strobe = 1'b0;
        o_pop    = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        finish   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_idx  = '0;
                n_pend = 1'b0;
                if (i_item_valid) begin
                    o_pop   = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (match || !issue) begin
                    finish = 1'b1;
                end else begin
                    rd_en  = 1'b1;
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end
                if (finish) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    wr_en    = !match && !full;
                    if (r_item.last) begin
                        n_count = '0;
                    end else if (wr_en) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // Current transaction and result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (finish) begin
            r_value_out <= r_item.value;
            r_keep      <= !match;
            r_last_out  <= r_item.last;
            r_overflow  <= !match && full;
        end
    end

    // Store of distinct values: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[AW-1:0]] <= r_item.value;
        end
        if (rd_en) begin
            r_rdata <= mem[r_idx[AW-1:0]];
        end
    end

    assign o_strobe    = r_strobe;
    assign o_value_out = r_value_out;
    assign o_keep      = r_keep;
    assign o_last_out  = r_last_out;
    assign o_overflow  = r_overflow;

    `SDR_ASSERT(a_count_bound, r_count <= CW'(DEPTH), "fill count above store depth")
    `SDR_ASSERT(a_strobe_idle, r_strobe |-> (r_state == S_IDLE),
        "result issued while a search is still running")
    `SDR_ASSERT(a_last_clears, (r_strobe && r_last_out) |-> (r_count == '0),
        "fill count not cleared after the last element")
    `SDR_ASSERT(a_pop_idle, o_pop |-> (r_state == S_IDLE), "pop while a search is running")

endmodule

// ===== rtl/core/stream_duplicate_remover_unit.sv =====
// With the engine idle, an accepted transaction passes the queue, the idle state that pops
// it and a scan of the stored entries, which reads one entry at a time through the single
// store read port (a hit ends the scan early), before its result strobes.
// The engine takes one transaction at a time; a two-entry queue takes transactions meanwhile.
// Reset is synchronous, active low: clears the queue, the fill count and the engine;
// the store is not cleared. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module stream_duplicate_remover_unit
    import sdr_pkg::*;
#(
    parameter int DEPTH = SDR_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SDR_VALUE_W-1:0] i_value,
    input  logic                          i_last,
    output logic                          o_strobe,
    output logic signed [SDR_VALUE_W-1:0] o_value_out,
    output logic                          o_keep,
    output logic                          o_last_out,
    output logic                          o_overflow
);

    logic  item_valid;
    t_item item;
    logic  pop;

    // Front: accepts transactions into the queue.
    sdr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .i_last       (i_last),
        .i_pop        (pop),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    // Back: searches the store and issues the results.
    sdr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_pop        (pop),
        .o_strobe     (o_strobe),
        .o_value_out  (o_value_out),
        .o_keep       (o_keep),
        .o_last_out   (o_last_out),
        .o_overflow   (o_overflow)
    );

endmodule

// ===== bench/stream_duplicate_remover_checker.sv =====
// Checker for the stream duplicate remover: watches the command and result ports,
// keeps its own first-occurrence store per list and compares every result strobe.
// Depends on sdr_pkg for the value width and the default store depth.
`timescale 1ns / 1ps

module stream_duplicate_remover_checker
    import sdr_pkg::*;
#(
    parameter int DEPTH = SDR_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic signed [SDR_VALUE_W-1:0] i_value,
    input  logic                          i_last,
    input  logic                          i_strobe,
    input  logic signed [SDR_VALUE_W-1:0] i_value_out,
    input  logic                          i_keep,
    input  logic                          i_last_out,
    input  logic                          i_overflow,
    output int                            o_mismatches,
    output int                            o_outstanding
);

    // One predicted result of the block.
    typedef struct packed {
        logic signed [SDR_VALUE_W-1:0] value;
        logic                          keep;
        logic                          last;
        logic                          overflow;
    } t_verdict;

    // Predicted results still waiting for their strobe, oldest first.
    t_verdict verdict_queue[$];

    // Distinct values of the current list and how many of them are valid.
    logic [SDR_VALUE_W-1:0] seen_store [DEPTH];
    int unsigned            seen_fill = 0;

    int mismatch_count = 0;
    int outstanding_count = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = outstanding_count;

    // Decides keep and overflow for one element and updates the list store.
    function automatic t_verdict classify_element(logic signed [SDR_VALUE_W-1:0] v,
                                                  logic l);
        t_verdict r;
        logic     hit;
        hit = 1'b0;
        for (int i = 0; i < int'(seen_fill); i++) begin
            if (seen_store[i] == v) begin
                hit = 1'b1;
            end
        end
        r.value    = v;
        r.last     = l;
        r.keep     = !hit;
        r.overflow = 1'b0;
        if (!hit) begin
            if (seen_fill < DEPTH) begin
                seen_store[seen_fill] = v;
                seen_fill++;
            end else begin
                r.overflow = 1'b1;
            end
        end
        // The list ends here, so the store starts over empty.
        if (l) begin
            seen_fill = 0;
        end
        return r;
    endfunction

    // Counts a failure; only the first ten are printed.
    function automatic void log_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // Results are compared before the new transaction is predicted, since a result
    // never leaves in the cycle its transaction is taken.
    always @(posedge i_clk) begin : watch_channels
        t_verdict want;
        if (!i_rst_n) begin
            seen_fill = 0;
            verdict_queue.delete();
        end else begin
            if (i_strobe) begin
                if (verdict_queue.size() == 0) begin
                    log_failure($sformatf(
                        "result with nothing outstanding: value=%h keep=%b last=%b ovf=%b",
                        i_value_out, i_keep, i_last_out, i_overflow));
                end else begin
                    want = verdict_queue.pop_front();
                    if (i_value_out !== want.value || i_keep !== want.keep ||
                        i_last_out !== want.last || i_overflow !== want.overflow) begin
                        log_failure($sformatf(
                            {"mismatch: expected value=%h keep=%b last=%b ovf=%b, ",
                             "got value=%h keep=%b last=%b ovf=%b"},
                            want.value, want.keep, want.last, want.overflow,
                            i_value_out, i_keep, i_last_out, i_overflow));
                    end
                end
            end
            if (i_start && !i_busy) begin
                verdict_queue.push_back(classify_element(i_value, i_last));
            end
        end
        outstanding_count = verdict_queue.size();
    end

endmodule

// ===== bench/stream_duplicate_remover_unit_test.sv =====
// Top of the duplicate remover bench: clock, reset, list stimulus with bursty
// transactions, a watchdog and the verdict. Depends on sdr_pkg, the block and
// stream_duplicate_remover_checker.
`timescale 1ns / 1ps

module stream_duplicate_remover_unit_test;
    import sdr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ELEMENT_TARGET = 400;
    localparam int SETTLE_CYCLES  = 2 * SDR_DEPTH + 8;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic signed [SDR_VALUE_W-1:0] i_value = '0;
    logic                          i_last = 1'b0;
    logic                          busy;
    logic                          o_strobe;
    logic signed [SDR_VALUE_W-1:0] o_value_out;
    logic                          o_keep;
    logic                          o_last_out;
    logic                          o_overflow;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    int elements_sent = 0;
    int burst_left = 0;

    stream_duplicate_remover_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .i_last     (i_last),
        .o_strobe   (o_strobe),
        .o_value_out(o_value_out),
        .o_keep     (o_keep),
        .o_last_out (o_last_out),
        .o_overflow (o_overflow)
    );

    stream_duplicate_remover_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_value      (i_value),
        .i_last       (i_last),
        .i_strobe     (o_strobe),
        .i_value_out  (o_value_out),
        .i_keep       (o_keep),
        .i_last_out   (o_last_out),
        .i_overflow   (o_overflow),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog: ends the run when neither side moves a transaction for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("stream_duplicate_remover_unit_test: errors");
            $finish;
        end
    end

    // Mostly short bursts, now and then a long stretch without gaps.
    function automatic int pick_burst_length();
        if ($urandom_range(0, 4) == 0) begin
            return $urandom_range(30, 60);
        end
        return $urandom_range(1, 12);
    endfunction

    // Offers one element at a falling edge and holds it until the block takes it.
    // At the end of a burst the start line drops for a random gap, unless the gap drawn is zero.
    task automatic send_element(input logic signed [SDR_VALUE_W-1:0] v, input logic l);
        int gap;
        start   <= 1'b1;
        i_value <= v;
        i_last  <= l;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        elements_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = pick_burst_length();
        end
    endtask

    // Fills the store to its end or past it, then repeats a mix of stored and unstored values.
    task automatic send_long_list();
        logic [SDR_VALUE_W-1:0] base;
        int                     n_distinct;
        int                     n_tail;
        base       = $urandom;
        n_distinct = SDR_DEPTH + $urandom_range(0, 6);
        n_tail     = $urandom_range(3, 10);
        for (int i = 0; i < n_distinct; i++) begin
            send_element(base + i, 1'b0);
        end
        for (int i = 0; i < n_tail; i++) begin
            send_element(base + $urandom_range(0, n_distinct + 3), i == n_tail - 1);
        end
    endtask

    // A short list drawn from a small pool, so repeats are common.
    task automatic send_short_list();
        logic [SDR_VALUE_W-1:0] base;
        int                     len;
        int                     pool;
        base = $urandom;
        len  = $urandom_range(1, 20);
        pool = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            send_element(base + $urandom_range(0, pool - 1), i == len - 1);
        end
    endtask

    initial begin
        int list_index;
        int mode;
        list_index = 0;
        burst_left = pick_burst_length();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Extreme values, sign patterns and duplicates, with a duplicate as the last element.
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h7FFF_FFFF, 1'b0);
        send_element(32'h0000_0000, 1'b0);
        send_element(32'hFFFF_FFFF, 1'b0);
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h0000_0001, 1'b0);
        send_element(32'h7FFF_FFFF, 1'b0);
        send_element(32'hFFFF_FFFE, 1'b0);
        send_element(32'h0000_0000, 1'b1);
        // A value from the previous list is new again after the last marker.
        send_element(32'h7FFF_FFFF, 1'b1);
        send_element(32'h0000_0005, 1'b0);
        send_element(32'h0000_0005, 1'b1);
        send_element(32'h0000_0005, 1'b1);
        send_element(32'hAAAA_AAAA, 1'b0);
        send_element(32'h5555_5555, 1'b0);
        send_element(32'hAAAA_AAAA, 1'b1);

        // Random lists; the first one always fills the store and may overflow it.
        while (elements_sent < ELEMENT_TARGET) begin
            mode = (list_index == 0) ? 0 : $urandom_range(0, 9);
            if (mode <= 1) begin
                send_long_list();
            end else if (mode == 2) begin
                // Noise: random values with a random last marker, often left open.
                repeat ($urandom_range(1, 8)) begin
                    send_element($urandom, $urandom_range(0, 3) == 0);
                end
            end else begin
                send_short_list();
            end
            list_index++;
        end
        start <= 1'b0;

        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("stream_duplicate_remover_unit_test: clean");
        end else begin
            $display("stream_duplicate_remover_unit_test: errors");
        end
        $finish;
    end

endmodule

// ===== stream_duplicate_remover_unit.f =====
+incdir+rtl/core
rtl/core/sdr_pkg.sv
rtl/core/sdr_front.sv
rtl/core/sdr_back.sv
rtl/core/stream_duplicate_remover_unit.sv
bench/stream_duplicate_remover_checker.sv
bench/stream_duplicate_remover_unit_test.sv
